// File: hw/rtl/rkcf_pkg.sv
// ----------------------------------------------------------------------------
// rkcf_pkg
// Shared types and constants of the rgb kernel convolution filter.
// ----------------------------------------------------------------------------
package rkcf_pkg;

  // filter modes
  localparam logic [1:0] MODE_BLUR    = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_SHARPEN = 2'd2;
  localparam logic [1:0] MODE_PENCIL  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  // reset values of the configuration registers
  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;

  // reciprocals for the constant divisions, quotient = (x * RECIP) >> SHIFT
  localparam logic [14:0] RECIP_44   = 15'd23832;
  localparam int          SHIFT_44   = 20;
  localparam logic [14:0] RECIP_6    = 15'd5462;
  localparam int          SHIFT_6    = 15;
  localparam logic [15:0] RECIP_3    = 16'd43691;
  localparam int          SHIFT_3    = 17;

  localparam logic signed [15:0] BIAS_EDGE   = 16'sd256;
  localparam logic signed [15:0] BIAS_PENCIL = 16'sd128;

  // per item control that travels with the pixel down the pipeline
  typedef struct packed {
    logic        emit;
    logic        interior;
    logic        last;
    logic [23:0] center;
  } side_t;

endpackage

// File: hw/rtl/rkcf_ram.sv
// ----------------------------------------------------------------------------
// rkcf_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module rkcf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/rgb_kernel_convolution_filter.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_filter
// 3x3 / 5x5 kernel convolution over a raster rgb pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side takes results and returns
// one result per pixel, each result belonging to the pixel fed 2W+2
// transactions earlier; until that many are in flight results carry tuser 0
// and zero data, and flush transactions (tuser 1) drain the end of a frame.
// Four line stores live in one 96-bit-wide RAM of MAX_WIDTH words, read at
// the input column and at the output column and written back from stage 1,
// with forwarding from the write in flight. The arithmetic runs through a
// registered pipeline, and the block sustains one transaction per cycle
// whenever the output side takes them. The line stores need no clearing pass
// after reset.
module rgb_kernel_convolution_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic        s_tuser,   // flush
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out, green_out, blue_out
  output logic        m_tuser,   // out_valid
  output logic        m_tlast    // frame_last
);
  import rkcf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = CW + 2;

  // configuration
  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  filter_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      filter_mode  <= MODE_BLUR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  image_width  <= cfg_data[11:0];
        CFG_HEIGHT: image_height <= cfg_data;
        CFG_MODE:   filter_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [13:0] wraw, hraw;
  logic [CW:0] w;
  logic [RW:0] h;
  logic [PW-1:0] lag;

  always_comb begin
    wraw = {2'b0, image_width};
    hraw = {1'b0, image_height};
    if (wraw < 14'd5) wraw = 14'd5;
    else if (wraw > 14'(MAX_WIDTH)) wraw = 14'(MAX_WIDTH);
    if (hraw < 14'd5) hraw = 14'd5;
    else if (hraw > 14'(MAX_HEIGHT)) hraw = 14'(MAX_HEIGHT);
    w   = (CW+1)'(wraw);
    h   = (RW+1)'(hraw);
    lag = {w, 1'b0} + PW'(2);
  end

  // pipeline control
  logic en, accept;
  logic vld [1:9];

  assign en       = !vld[9] || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // position counters, evaluated for the item at the input
  logic [CW-1:0] in_column, out_column, col, oc, col_next, oc_next;
  logic [RW-1:0] in_row, out_row, row, orow, row_next, orow_next;
  logic [PW-1:0] pending_count, pending_next;
  logic          flush, ignore, emit, last, interior;
  logic [1:0]    border;
  logic [RW-1:0] in_row_next;
  logic [CW-1:0] in_column_next;

  always_comb begin
    flush  = s_tuser;
    ignore = flush && (pending_count == '0);
    emit   = pending_count >= lag;
    col    = ({1'b0, in_column} < w) ? in_column : '0;
    row    = ({1'b0, in_row} < h) ? in_row : '0;
    oc     = ({1'b0, out_column} < w) ? out_column : '0;
    orow   = ({1'b0, out_row} < h) ? out_row : '0;

    col_next = col;
    row_next = row;
    if (({1'b0, col} + 1'b1) >= w) begin
      col_next = '0;
      row_next = (({1'b0, row} + 1'b1) >= h) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end

    oc_next   = oc;
    orow_next = orow;
    if (({1'b0, oc} + 1'b1) >= w) begin
      oc_next   = '0;
      orow_next = (({1'b0, orow} + 1'b1) >= h) ? '0 : orow + 1'b1;
    end else begin
      oc_next = oc + 1'b1;
    end

    border   = (filter_mode == MODE_BLUR || filter_mode == MODE_PENCIL) ? 2'd2 : 2'd1;
    interior = ({1'b0, orow} >= (RW+1)'(border)) && ({1'b0, orow} < h - (RW+1)'(border))
            && ({1'b0, oc} >= (CW+1)'(border)) && ({1'b0, oc} < w - (CW+1)'(border));
    last     = ({1'b0, orow} == h - 1'b1) && ({1'b0, oc} == w - 1'b1);

    pending_next   = pending_count;
    in_column_next = in_column;
    in_row_next    = in_row;
    if (!ignore) begin
      in_column_next = col_next;
      in_row_next    = row_next;
      if (!emit) begin
        pending_next = pending_count + 1'b1;
      end else if (flush && last) begin
        pending_next   = '0;
        in_column_next = '0;
        in_row_next    = '0;
      end else begin
        pending_next = lag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      pending_count <= '0;
    end else if (accept) begin
      in_column     <= in_column_next;
      in_row        <= in_row_next;
      pending_count <= pending_next;
      if (!ignore && emit) begin
        out_column <= oc_next;
        out_row    <= orow_next;
      end
    end
  end

  // stage 1: line store read data arrives, write back
  logic          upd1;
  logic [23:0]   px1;
  logic [CW-1:0] col1, oc1;
  side_t         sd [1:9];
  logic          fa1, fb1;
  logic [95:0]   fwd1, rdata_a, rdata_b, word_a, word_b, wdata;
  logic          we;
  logic [23:0]   center1;

  always_comb begin
    word_a  = fa1 ? fwd1 : rdata_a;
    word_b  = fb1 ? fwd1 : rdata_b;
    wdata   = {word_a[71:0], px1};
    we      = en && vld[1] && upd1;
    center1 = (oc1 == col1) ? word_a[47:24] : word_b[71:48];
  end

  rkcf_ram #(
    .WIDTH (96),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (we),
    .waddr   (col1),
    .wdata   (wdata),
    .re      (accept),
    .raddr_a (col),
    .rdata_a (rdata_a),
    .raddr_b (oc),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      upd1 <= !ignore;
      px1  <= flush ? 24'd0 : s_tdata;
      col1 <= col;
      oc1  <= oc;
      // forward the write in flight when the new read hits the same word
      fa1  <= vld[1] && upd1 && (col1 == col);
      fb1  <= vld[1] && upd1 && (col1 == oc);
      fwd1 <= wdata;
      sd[1].emit     <= !ignore && emit;
      sd[1].interior <= interior;
      sd[1].last     <= last;
      sd[1].center   <= '0;
    end
  end

  // 5x5 window, rows top to bottom, columns left to right
  logic [23:0] win [5][5];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win[r][c] <= win[r][c+1];
        end
      end
      win[0][4] <= word_a[95:72];
      win[1][4] <= word_a[71:48];
      win[2][4] <= word_a[47:24];
      win[3][4] <= word_a[23:0];
      win[4][4] <= px1;
    end
  end

  // stage 3: group sums per channel
  logic [10:0] rsum [3][5];
  logic [10:0] i8   [3];
  logic [9:0]  m4   [3];
  logic [9:0]  x4   [3];
  logic [7:0]  cpx  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 5; r++) begin
          rsum[k][r] <= 11'(win[r][0][8*k +: 8]) + 11'(win[r][1][8*k +: 8])
                      + 11'(win[r][2][8*k +: 8]) + 11'(win[r][3][8*k +: 8])
                      + 11'(win[r][4][8*k +: 8]);
        end
        i8[k] <= 11'(win[1][1][8*k +: 8]) + 11'(win[1][2][8*k +: 8])
               + 11'(win[1][3][8*k +: 8]) + 11'(win[2][1][8*k +: 8])
               + 11'(win[2][3][8*k +: 8]) + 11'(win[3][1][8*k +: 8])
               + 11'(win[3][2][8*k +: 8]) + 11'(win[3][3][8*k +: 8]);
        m4[k] <= 10'(win[0][2][8*k +: 8]) + 10'(win[2][0][8*k +: 8])
               + 10'(win[2][4][8*k +: 8]) + 10'(win[4][2][8*k +: 8]);
        x4[k] <= 10'(win[1][2][8*k +: 8]) + 10'(win[2][1][8*k +: 8])
               + 10'(win[2][3][8*k +: 8]) + 10'(win[3][2][8*k +: 8]);
        cpx[k] <= win[2][2][8*k +: 8];
      end
    end
  end

  // stage 4: kernel sum per mode
  logic signed [15:0] ks   [3];
  logic        [13:0] kabs [3];
  logic               kneg [3];
  logic signed [15:0] ks_c [3];
  logic signed [15:0] asum, cs;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      asum = 16'(rsum[k][0]) + 16'(rsum[k][1]) + 16'(rsum[k][2])
           + 16'(rsum[k][3]) + 16'(rsum[k][4]);
      cs   = 16'(cpx[k]);
      case (filter_mode)
        MODE_BLUR:    ks_c[k] = asum + 16'(i8[k]) + 16'(m4[k]) + cs * 16'sd7;
        MODE_EDGE:    ks_c[k] = cs * 16'sd9 - 16'(i8[k]);
        MODE_SHARPEN: ks_c[k] = cs * 16'sd10 - 16'(x4[k]);
        default:      ks_c[k] = cs * 16'sd35 - asum - 16'(i8[k]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ks[k]   <= ks_c[k];
        kneg[k] <= ks_c[k][15];
        kabs[k] <= ks_c[k][15] ? 14'(-ks_c[k]) : 14'(ks_c[k]);
      end
    end
  end

  // stage 5: reciprocal multiply
  logic        [28:0] prod  [3];
  logic signed [15:0] ks5   [3];
  logic               kneg5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k]  <= 29'(kabs[k]) * ((filter_mode == MODE_BLUR) ? 29'(RECIP_44) : 29'(RECIP_6));
        ks5[k]   <= ks[k];
        kneg5[k] <= kneg[k];
      end
    end
  end

  // stage 6: quotient, sign and bias
  logic signed [15:0] acc   [3];
  logic signed [15:0] acc_c [3];
  logic        [13:0] quo;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo = (filter_mode == MODE_BLUR) ? 14'(prod[k] >> SHIFT_44) : 14'(prod[k] >> SHIFT_6);
      case (filter_mode)
        MODE_BLUR, MODE_SHARPEN: acc_c[k] = kneg5[k] ? -16'(quo) : 16'(quo);
        MODE_EDGE:               acc_c[k] = ks5[k] + BIAS_EDGE;
        default:                 acc_c[k] = ks5[k] + BIAS_PENCIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= acc_c[k];
      end
    end
  end

  // stage 7: grey sum
  logic signed [17:0] gsum;
  logic        [14:0] gabs;
  logic               gneg;
  logic        [7:0]  acc7 [3];

  assign gsum = 18'(acc[0]) + 18'(acc[1]) + 18'(acc[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      gneg <= gsum[17];
      gabs <= gsum[17] ? 15'(-gsum) : 15'(gsum);
      for (int k = 0; k < 3; k++) begin
        acc7[k] <= acc[k][7:0];
      end
    end
  end

  // stage 8: divide by three
  logic [30:0] gprod;
  logic        gneg8;
  logic [7:0]  acc8 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      gprod <= 31'(gabs) * 31'(RECIP_3);
      gneg8 <= gneg;
      for (int k = 0; k < 3; k++) begin
        acc8[k] <= acc7[k];
      end
    end
  end

  // stage 9: result select, output register
  logic [7:0]  gq, grey;
  logic [23:0] res, data9;

  always_comb begin
    gq   = 8'(gprod >> SHIFT_3);
    grey = gneg8 ? -gq : gq;
    res  = (filter_mode == MODE_PENCIL) ? {grey, grey, grey} : {acc8[2], acc8[1], acc8[0]};
    if (!sd[8].emit) data9 = '0;
    else if (sd[8].interior) data9 = res;
    else data9 = sd[8].center;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[2]        <= sd[1];
      sd[2].center <= center1;
      for (int k = 3; k <= 9; k++) begin
        sd[k] <= sd[k-1];
      end
      m_tdata <= data9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 9; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= accept;
      for (int k = 2; k <= 9; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign m_tvalid = vld[9];
  assign m_tuser  = sd[9].emit;
  assign m_tlast  = sd[9].emit && sd[9].last;

endmodule

// File: tb/rkcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkcf_checker
// Watches the configuration, pixel and result channels of the convolution
// filter, keeps its own model of the line stores and the 5x5 window, and
// compares every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module rkcf_checker
  import rkcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          outstanding,
  output int          fill_level,
  output int          pixels_seen,
  output int          frames_seen
);

  localparam int MAX_W = 2048;
  localparam int MAX_H = 4096;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_result_t;

  logic [23:0]   line_mem [4*MAX_W];
  logic [23:0]   win [25];
  logic [11:0]   width_reg;
  logic [12:0]   height_reg;
  logic [1:0]    mode_reg;
  int unsigned   in_col, in_row, out_col, out_row, pend;
  pixel_result_t expected_q [$];

  function automatic int kernel_weight(input logic [1:0] m, input int i);
    int r, c, dr, dc, d;
    r  = i / 5;
    c  = i % 5;
    dr = (r > 2) ? r - 2 : 2 - r;
    dc = (c > 2) ? c - 2 : 2 - c;
    d  = (dr > dc) ? dr : dc;
    case (m)
      MODE_BLUR: begin
        if (d == 0) return 8;
        if (r == 2 || c == 2 || d == 1) return 2;
        return 1;
      end
      MODE_EDGE: begin
        if (d == 0) return 9;
        return (d == 1) ? -1 : 0;
      end
      MODE_SHARPEN: begin
        if (d == 0) return 10;
        return (dr + dc == 1) ? -1 : 0;
      end
      default: begin
        if (d == 0) return 34;
        return (d == 1) ? -2 : -1;
      end
    endcase
  endfunction

  function automatic int unsigned eff_w();
    if (width_reg < 5) return 5;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg < 5) return 5;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  task automatic convolve(output logic [7:0] res [3]);
    int acc [3];
    int s, g;
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int i = 0; i < 25; i++)
        s += int'(win[i][8*c +: 8]) * kernel_weight(mode_reg, i);
      case (mode_reg)
        MODE_BLUR:    acc[c] = s / 44;
        MODE_EDGE:    acc[c] = s + 256;
        MODE_SHARPEN: acc[c] = s / 6;
        default:      acc[c] = s + 128;
      endcase
    end
    if (mode_reg == MODE_PENCIL) begin
      g = (acc[0] + acc[1] + acc[2]) / 3;
      acc[0] = g; acc[1] = g; acc[2] = g;
    end
    for (int c = 0; c < 3; c++) res[c] = acc[c][7:0];
  endtask

  // advance the model by one accepted pixel transaction
  task automatic predict_pixel(input logic flush, input logic [23:0] data);
    int unsigned   w, h, lag, col, r, oc, orow, b;
    logic [23:0]   px, center;
    logic [7:0]    rgb [3];
    pixel_result_t res;
    w   = eff_w();
    h   = eff_h();
    lag = 2 * w + 2;
    res = '0;
    if (flush && pend == 0) begin
      expected_q.push_back(res);
      return;
    end
    px  = flush ? 24'd0 : data;
    col = (in_col < w) ? in_col : 0;
    for (int k = 0; k < 5; k++)
      for (int j = 0; j < 4; j++) win[k*5+j] = win[k*5+j+1];
    win[4]  = line_mem[3*MAX_W + col];
    win[9]  = line_mem[2*MAX_W + col];
    win[14] = line_mem[1*MAX_W + col];
    win[19] = line_mem[col];
    win[24] = px;
    line_mem[3*MAX_W + col] = line_mem[2*MAX_W + col];
    line_mem[2*MAX_W + col] = line_mem[1*MAX_W + col];
    line_mem[1*MAX_W + col] = line_mem[col];
    line_mem[col] = px;
    r = (in_row < h) ? in_row : 0;
    col++;
    if (col >= w) begin
      col = 0;
      r++;
      if (r >= h) r = 0;
    end
    in_col = col;
    in_row = r;
    if (pend < lag) begin
      pend++;
      expected_q.push_back(res);
      return;
    end
    pend   = lag;
    oc     = (out_col < w) ? out_col : 0;
    orow   = (out_row < h) ? out_row : 0;
    center = line_mem[2*MAX_W + oc];
    b = (mode_reg == MODE_BLUR || mode_reg == MODE_PENCIL) ? 2 : 1;
    if (orow >= b && orow < h - b && oc >= b && oc < w - b) begin
      convolve(rgb);
    end else begin
      rgb[0] = center[7:0];
      rgb[1] = center[15:8];
      rgb[2] = center[23:16];
    end
    res.valid = 1'b1;
    res.red   = rgb[0];
    res.green = rgb[1];
    res.blue  = rgb[2];
    res.last  = (orow == h - 1) && (oc == w - 1);
    expected_q.push_back(res);
    oc++;
    if (oc >= w) begin
      oc = 0;
      orow++;
      if (orow >= h) orow = 0;
    end
    out_col = oc;
    out_row = orow;
    if (flush && res.last) begin
      pend   = 0;
      in_col = 0;
      in_row = 0;
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t exp_r, got;
    if (rst) begin
      width_reg  <= RST_WIDTH;
      height_reg <= RST_HEIGHT;
      mode_reg   <= MODE_BLUR;
      for (int i = 0; i < 4*MAX_W; i++) line_mem[i] = '0;
      for (int i = 0; i < 25; i++) win[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; pend = 0;
      expected_q.delete();
      fail_count  <= 0;
      pixels_seen <= 0;
      frames_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg  = cfg_data[11:0];
          CFG_HEIGHT: height_reg = cfg_data;
          CFG_MODE:   mode_reg   = cfg_data[1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_pixel(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("tb: unexpected result transaction %h at %0t", got, $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10)
              $display("tb: mismatch valid/r/g/b/last exp %b %h %h %h %b got %b %h %h %h %b",
                       exp_r.valid, exp_r.red, exp_r.green, exp_r.blue, exp_r.last,
                       got.valid, got.red, got.green, got.blue, got.last);
            fail_count <= fail_count + 1;
          end
          if (got.valid) pixels_seen <= pixels_seen + 1;
          if (got.last) frames_seen <= frames_seen + 1;
        end
      end
    end
    outstanding = expected_q.size();
    fill_level  = pend;
  end

endmodule

// File: tb/rgb_kernel_convolution_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_filter_test
// Stimulus and verdict for the rgb kernel convolution filter.
// ----------------------------------------------------------------------------
// Runs small frames in all four kernel modes, out of range sizes, frames back
// to back, stray flushes, mode and height changes while a frame is in flight,
// and one very wide frame under a long output stall. Both sides idle at
// random; the checker module predicts and compares every result.
module rgb_kernel_convolution_filter_test;
  import rkcf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [12:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fail_count, outstanding, fill_level, pixels_seen, frames_seen;
  int items_sent = 0;
  int cfg_writes = 0;
  int hold_request = 0;
  bit no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_kernel_convolution_filter uut (.*);

  rkcf_checker chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .fail_count, .outstanding, .fill_level, .pixels_seen, .frames_seen
  );

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        m_tready = 1'b0;
        hold_request--;
      end else if (no_gaps) begin
        m_tready = 1'b1;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 9) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  task automatic idle_gap();
    int r;
    if (no_gaps) return;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    if (r < 90) repeat ($urandom_range(1, 3)) @(negedge clk);
    else if (r < 98) repeat ($urandom_range(4, 12)) @(negedge clk);
    else repeat ($urandom_range(20, 60)) @(negedge clk);
  endtask

  task automatic send_item(input logic flush, input logic [23:0] data);
    idle_gap();
    s_tvalid = 1'b1;
    s_tuser  = flush;
    s_tdata  = flush ? 24'($urandom) : data;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    items_sent++;
  endtask

  // wait for all results, then let the pipeline go quiet
  task automatic settle();
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [23:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                 8'($urandom_range(0, 1) * 255)};
      default: return 24'($urandom);
    endcase
  endfunction

  // flush until the model reports an empty pipeline
  task automatic drain();
    while (fill_level != 0) send_item(1'b1, '0);
  endtask

  task automatic run_frame(input int w, input int h, input logic [1:0] mode,
                           input bit extremes, input bit noise);
    settle();
    drain();
    settle();
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
    write_reg(CFG_MODE, 13'(mode));
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 30) == 0) send_item(1'b1, '0);
      send_item(1'b0, extremes ? (((i / 2) % 2) ? 24'hffffff : 24'h000000)
                               : pick_pixel());
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // flushes into an empty pipeline are dropped
    send_item(1'b1, '0);
    send_item(1'b1, '0);

    // directed: checkerboard-ish extremes in blur, edge and pencil, random pixels in sharpen
    run_frame(5, 5, MODE_BLUR, 1'b1, 1'b0);
    run_frame(5, 5, MODE_EDGE, 1'b1, 1'b0);
    run_frame(5, 5, MODE_SHARPEN, 1'b0, 1'b0);
    run_frame(5, 5, MODE_PENCIL, 1'b1, 1'b0);
    // sizes below range are clamped to 5
    run_frame(3, 0, MODE_PENCIL, 1'b0, 1'b0);

    // random small frames, often back to back, with stray flushes
    while (items_sent < 800) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      run_frame($urandom_range(5, 12), $urandom_range(5, 8), 2'($urandom_range(0, 3)),
                1'b0, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // change mode and height while the frame is still in flight
        settle();
        write_reg(CFG_MODE, 13'($urandom_range(0, 3)));
        write_reg(CFG_HEIGHT, 13'($urandom_range(5, 9)));
        repeat ($urandom_range(1, 10)) send_item(1'b0, pick_pixel());
      end
    end
    no_gaps = 1'b0;

    // tall frame beyond the height limit, cut short by a height change
    run_frame(5, 8191, MODE_EDGE, 1'b0, 1'b0);
    repeat (40) send_item(1'b0, pick_pixel());
    settle();
    write_reg(CFG_HEIGHT, 13'd5);
    drain();

    // widest frame with a long output hold-off so the input stalls
    settle();
    write_reg(CFG_WIDTH, 13'd4095);
    write_reg(CFG_HEIGHT, 13'd5);
    write_reg(CFG_MODE, 13'(MODE_PENCIL));
    hold_request = 3000;
    no_gaps = 1'b1;
    for (int i = 0; i < 2048 * 5; i++) send_item(1'b0, pick_pixel());
    no_gaps = 1'b0;
    drain();
    settle();
    write_reg(CFG_WIDTH, 13'd2048);
    write_reg(CFG_MODE, 13'(MODE_SHARPEN));
    run_frame(2048, 5, MODE_SHARPEN, 1'b0, 1'b0);
    drain();

    while (outstanding != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("tb: %0d pixel transactions, %0d register writes, all four kernels",
             items_sent, cfg_writes);
    $display("tb: %0d frame pixels and %0d frame ends checked", pixels_seen, frames_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rkcf_pkg.sv
hw/rtl/rkcf_ram.sv
hw/rtl/rgb_kernel_convolution_filter.sv
tb/rkcf_checker.sv
tb/rgb_kernel_convolution_filter_test.sv
